/* rtl/cnv_pkg.sv */
package cnv_pkg;

  localparam int unsigned StackDepth  = 8;
  localparam int unsigned DescEntries = 16;
  localparam int unsigned SlotW       = $clog2(DescEntries);
  localparam int unsigned StkIdxW     = $clog2(StackDepth);
  localparam int unsigned LevelW      = 4;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_PUSH   = 3'd1,
    KIND_POP    = 3'd2,
    KIND_VERIFY = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_FINAL  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_WRONG_SZ  = 4'd1,
    ST_TOO_SMALL = 4'd2,
    ST_TWICE     = 4'd3,
    ST_OUTSIDE   = 4'd4,
    ST_EMPTY     = 4'd5,
    ST_PAST_END  = 4'd6,
    ST_MISSING   = 4'd7,
    ST_NONE_FIN  = 4'd8,
    ST_ADV_OVER  = 4'd9,
    ST_FULL      = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_MISS,
    S_SCAN_POP,
    S_COMPACT,
    S_FINAL_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] chunk_id;
    logic [63:0] chunk_size;
    logic [63:0] begin_pos;
    logic [63:0] end_pos;
    logic [63:0] adv_len;
    logic [3:0]  desc_slot;
    logic        desc_exact;
    logic        desc_once;
    logic [15:0] desc_required;
    logic        desc_finish;
  } cnv_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] chunk_id_out;
    logic [63:0] chunk_size_out;
    logic        finish_event;
    logic [15:0] missing_mask;
    logic [3:0]  level;
    logic        last;
  } cnv_out_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;      // register the input item and look up the ID
    logic exec_simple;  // load, push, verify, clear, pop errors, final on empty stack: one result
    logic scan_start;   // set the scan index to the top entry
    logic scan_step;    // examine one entry and move down
    logic scan_pop;     // pop scan (emit pops) rather than missing scan
    logic scan_final;   // final check scan
    logic emit_tail;    // emit trailing single result (status 8 or final ok)
    logic compact_step; // move one entry during compaction
    logic compact_start;
  } cnv_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  past_end;
    logic  scan_done;
    logic  any_hit;      // a missing result was produced, or a pop was found
    logic  compact_done;
  } cnv_sts_t;

endpackage

/* rtl/cnv_ctrl.sv */
module cnv_ctrl
  import cnv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  cnv_sts_t sts_i,
  output cnv_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts_i.kind == KIND_POP && !sts_i.empty && !sts_i.past_end) begin
          state_d = S_SCAN_MISS;
        end else if (sts_i.kind == KIND_FINAL && !sts_i.empty) begin
          state_d = S_FINAL_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN_MISS: begin
        if (sts_i.scan_done) state_d = sts_i.any_hit ? S_IDLE : S_SCAN_POP;
      end
      S_SCAN_POP: begin
        if (sts_i.scan_done) state_d = sts_i.any_hit ? S_COMPACT : S_IDLE;
      end
      S_COMPACT: begin
        if (sts_i.compact_done) state_d = S_IDLE;
      end
      S_FINAL_SCAN: begin
        if (sts_i.scan_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: cmd_o.capture = start_i;
      S_DECIDE: begin
        priority if (sts_i.kind == KIND_POP && !sts_i.empty && !sts_i.past_end) begin
          cmd_o.scan_start = 1'b1;
        end else if (sts_i.kind == KIND_FINAL && !sts_i.empty) begin
          cmd_o.scan_start = 1'b1;
        end else begin
          cmd_o.exec_simple = 1'b1;
        end
      end
      S_SCAN_MISS: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done && !sts_i.any_hit) cmd_o.scan_start = 1'b1;
      end
      S_SCAN_POP: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_pop  = 1'b1;
        if (sts_i.scan_done && !sts_i.any_hit) cmd_o.emit_tail = 1'b1;
        if (sts_i.scan_done && sts_i.any_hit) cmd_o.compact_start = 1'b1;
      end
      S_COMPACT: cmd_o.compact_step = 1'b1;
      S_FINAL_SCAN: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.scan_final = 1'b1;
        if (sts_i.scan_done && !sts_i.any_hit) cmd_o.emit_tail = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_DECIDE)
    else $error("start not taken");
  a_decide_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DECIDE |=> state_q != S_DECIDE)
    else $error("decide held");
  a_compact_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_COMPACT) |-> $past(state_q) == S_SCAN_POP)
    else $error("compaction without pop scan");
`endif

endmodule

/* rtl/cnv_dp.sv */
module cnv_dp
  import cnv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cnv_in_t  in_i,
  input  cnv_cmd_t cmd_i,
  output cnv_sts_t sts_o,
  output logic     res_valid_o,
  output cnv_out_t res_o
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);

  // Descriptor table.
  logic [31:0] desc_id_q   [DescEntries];
  logic [63:0] desc_bound_q[DescEntries];
  logic [15:0] desc_req_q  [DescEntries];
  logic [DescEntries-1:0] dvalid_q, dexact_q, donce_q, dfin_q;

  // Chunk stack.
  logic [31:0]      sid_q   [StackDepth];
  logic [63:0]      ssize_q [StackDepth];
  logic [63:0]      send_q  [StackDepth];
  logic [SlotW:0]   sdesc_q [StackDepth];
  logic [15:0]      sseen_q [StackDepth];
  logic [CntW-1:0]  cnt_q;

  cnv_in_t          it_q;
  logic             hit_q;
  logic [SlotW-1:0] slot_q;
  logic [CntW-1:0]  scan_q;     // entries left to scan; index is scan_q-1
  logic [CntW-1:0]  newcnt_q;   // level after pops so far
  logic             any_q;
  logic [CntW-1:0]  rd_q, wr_q; // compaction pointers
  logic             res_valid_q;
  cnv_out_t         res_q;

  // Lowest valid matching slot.
  logic             lk_hit;
  logic [SlotW-1:0] lk_slot;
  always_comb begin
    lk_hit  = 1'b0;
    lk_slot = '0;
    for (int s = DescEntries - 1; s >= 0; s--) begin
      if (dvalid_q[s] && desc_id_q[s] == in_i.chunk_id) begin
        lk_hit  = 1'b1;
        lk_slot = SlotW'(s);
      end
    end
  end

  logic [StkIdxW-1:0] top_idx, scan_idx;
  assign top_idx  = StkIdxW'(cnt_q - CntW'(1));
  assign scan_idx = StkIdxW'(scan_q - CntW'(1));

  logic [DescEntries-1:0] req_mask_16;
  logic [15:0] miss_at_scan;
  logic        fin_at_scan;
  always_comb begin
    miss_at_scan = '0;
    fin_at_scan  = 1'b0;
    if (sdesc_q[scan_idx] != '0) begin
      miss_at_scan = desc_req_q[SlotW'(sdesc_q[scan_idx] - 1'b1)] & ~sseen_q[scan_idx];
      fin_at_scan  = dfin_q[SlotW'(sdesc_q[scan_idx] - 1'b1)];
    end
  end
  assign req_mask_16 = '1;

  logic match_at_scan;
  assign match_at_scan = (send_q[scan_idx] == it_q.end_pos);

  logic [64:0] adv_sum;
  assign adv_sum = {1'b0, it_q.end_pos} + {1'b0, it_q.adv_len};

  logic [DescEntries-1:0] slot_bit;
  assign slot_bit = DescEntries'(1) << slot_q;

  assign sts_o.kind         = kind_e'(it_q.kind);
  assign sts_o.empty        = (cnt_q == '0);
  assign sts_o.past_end     = (cnt_q != '0) && (it_q.end_pos > send_q[top_idx]);
  assign sts_o.scan_done    = (scan_q == CntW'(1)) || (scan_q == '0);
  assign sts_o.any_hit      = any_q || (scan_q != '0 && (cmd_i.scan_pop ? match_at_scan
                               : (match_at_scan || cmd_i.scan_final) && miss_at_scan != '0));
  assign sts_o.compact_done = (rd_q >= cnt_q);

  function automatic cnv_out_t mk(status_e st, logic [31:0] id, logic [63:0] sz,
                                  logic fin, logic [15:0] miss, logic [CntW-1:0] lvl);
    cnv_out_t r;
    r.status         = st;
    r.chunk_id_out   = id;
    r.chunk_size_out = sz;
    r.finish_event   = fin;
    r.missing_mask   = miss;
    r.level          = LevelW'(lvl);
    r.last           = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dvalid_q    <= '0;
      dexact_q    <= '0;
      donce_q     <= '0;
      dfin_q      <= '0;
      res_valid_q <= 1'b0;
      scan_q      <= '0;
      any_q       <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cmd_i.capture) begin
        it_q   <= in_i;
        hit_q  <= lk_hit;
        slot_q <= lk_slot;
      end
      if (cmd_i.exec_simple) begin
        res_valid_q <= (it_q.kind <= 3'(KIND_FINAL));
        res_q <= mk(ST_OK, '0, '0, 1'b0, '0, cnt_q);
        unique case (it_q.kind)
          KIND_LOAD: begin
            if (32'(it_q.desc_slot) < DescEntries) begin
              desc_id_q[SlotW'(it_q.desc_slot)]    <= it_q.chunk_id;
              desc_bound_q[SlotW'(it_q.desc_slot)] <= it_q.chunk_size;
              desc_req_q[SlotW'(it_q.desc_slot)]   <= it_q.desc_required & 16'(req_mask_16);
              dvalid_q[SlotW'(it_q.desc_slot)]     <= 1'b1;
              dexact_q[SlotW'(it_q.desc_slot)]     <= it_q.desc_exact;
              donce_q[SlotW'(it_q.desc_slot)]      <= it_q.desc_once;
              dfin_q[SlotW'(it_q.desc_slot)]       <= it_q.desc_finish;
            end
          end
          KIND_PUSH: begin
            priority if (hit_q && dexact_q[slot_q]
                         && it_q.chunk_size != desc_bound_q[slot_q]) begin
              res_q <= mk(ST_WRONG_SZ, it_q.chunk_id, '0, 1'b0, '0, cnt_q);
            end else if (hit_q && !dexact_q[slot_q]
                         && it_q.chunk_size < desc_bound_q[slot_q]) begin
              res_q <= mk(ST_TOO_SMALL, it_q.chunk_id, '0, 1'b0, '0, cnt_q);
            end else if (hit_q && cnt_q != '0 && donce_q[slot_q]
                         && (sseen_q[top_idx] & 16'(slot_bit)) != '0) begin
              res_q <= mk(ST_TWICE, it_q.chunk_id, '0, 1'b0, '0, cnt_q);
            end else begin
              if (hit_q && cnt_q != '0) sseen_q[top_idx] <= sseen_q[top_idx] | 16'(slot_bit);
              priority if (cnt_q != '0 && (it_q.begin_pos > send_q[top_idx]
                                          || it_q.end_pos > send_q[top_idx])) begin
                res_q <= mk(ST_OUTSIDE, it_q.chunk_id, '0, 1'b0, '0, cnt_q);
              end else if (cnt_q >= CntW'(StackDepth)) begin
                res_q <= mk(ST_FULL, it_q.chunk_id, '0, 1'b0, '0, cnt_q);
              end else begin
                sid_q[StkIdxW'(cnt_q)]   <= it_q.chunk_id;
                ssize_q[StkIdxW'(cnt_q)] <= it_q.chunk_size;
                send_q[StkIdxW'(cnt_q)]  <= it_q.end_pos;
                sdesc_q[StkIdxW'(cnt_q)] <= hit_q ? {1'b0, slot_q} + 1'b1 : '0;
                sseen_q[StkIdxW'(cnt_q)] <= '0;
                cnt_q <= cnt_q + 1'b1;
                res_q <= mk(ST_OK, '0, '0, 1'b0, '0, cnt_q + 1'b1);
              end
            end
          end
          KIND_POP: begin
            if (cnt_q == '0) res_q <= mk(ST_EMPTY, '0, '0, 1'b0, '0, '0);
            else res_q <= mk(ST_PAST_END, sid_q[top_idx], '0, 1'b0, '0, cnt_q);
          end
          KIND_VERIFY: begin
            if (cnt_q != '0 && (adv_sum[64] || adv_sum[63:0] > send_q[top_idx]))
              res_q <= mk(ST_ADV_OVER, sid_q[top_idx], '0, 1'b0, '0, cnt_q);
          end
          KIND_CLEAR: begin
            cnt_q <= '0;
            res_q <= mk(ST_OK, '0, '0, 1'b0, '0, '0);
          end
          KIND_FINAL: ;
          default: ;
        endcase
      end
      if (cmd_i.scan_step && scan_q != '0) begin
        scan_q <= scan_q - 1'b1;
        if (cmd_i.scan_pop) begin
          if (match_at_scan) begin
            any_q       <= 1'b1;
            newcnt_q    <= newcnt_q - 1'b1;
            res_valid_q <= 1'b1;
            res_q <= mk(ST_OK, sid_q[scan_idx], ssize_q[scan_idx], fin_at_scan, '0,
                        newcnt_q - 1'b1);
          end
        end else if ((match_at_scan || cmd_i.scan_final) && miss_at_scan != '0) begin
          any_q       <= 1'b1;
          res_valid_q <= 1'b1;
          res_q <= mk(ST_MISSING, sid_q[scan_idx], '0, 1'b0, miss_at_scan, cnt_q);
        end
      end
      // Results are registered before "last" is settled, so the last flag of the final hit
      // is set when the scan closes rather than on the hit itself.
      if (cmd_i.scan_start) begin
        scan_q   <= cnt_q;
        newcnt_q <= cnt_q;
        any_q    <= 1'b0;
      end
      if (cmd_i.emit_tail) begin
        res_valid_q <= 1'b1;
        res_q <= mk(cmd_i.scan_final ? ST_OK : ST_NONE_FIN, '0, '0, 1'b0, '0, cnt_q);
      end
      if (cmd_i.compact_start) begin
        rd_q <= '0;
        wr_q <= '0;
      end
      if (cmd_i.compact_step) begin
        if (rd_q < cnt_q) begin
          if (send_q[StkIdxW'(rd_q)] != it_q.end_pos) begin
            sid_q[StkIdxW'(wr_q)]   <= sid_q[StkIdxW'(rd_q)];
            ssize_q[StkIdxW'(wr_q)] <= ssize_q[StkIdxW'(rd_q)];
            send_q[StkIdxW'(wr_q)]  <= send_q[StkIdxW'(rd_q)];
            sdesc_q[StkIdxW'(wr_q)] <= sdesc_q[StkIdxW'(rd_q)];
            sseen_q[StkIdxW'(wr_q)] <= sseen_q[StkIdxW'(rd_q)];
            wr_q <= wr_q + 1'b1;
          end
          rd_q <= rd_q + 1'b1;
        end else begin
          cnt_q <= wr_q;
        end
      end
    end
  end

  // A hit is held in a pending register so that "last" can be settled when the
  // scan knows whether a further hit follows. A hit that closes the scan while
  // another is held is itself held and then goes out as the last one.
  logic     scan_end;
  logic     scan_end_q, flush_q;
  logic     pend_q, pend_last_q;
  cnv_out_t pend_r_q;
  assign scan_end = cmd_i.scan_step && (scan_q == CntW'(1) || scan_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_end_q  <= 1'b1;
      flush_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      scan_end_q <= !cmd_i.scan_step || scan_end;
      flush_q    <= scan_end;
      if (res_valid_q && (pend_q || !scan_end_q)) begin
        pend_q      <= 1'b1;
        pend_r_q    <= res_q;
        pend_last_q <= scan_end_q;
      end else if (pend_q && (flush_q || pend_last_q)) begin
        pend_q      <= 1'b0;
        pend_last_q <= 1'b0;
      end
    end
  end

  // Output: a pending hit goes out when the next hit arrives (not last) or when
  // the scan ends with no further hit (last); other results go straight out as last.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = res_q;
    if (pend_q && (res_valid_q || flush_q || pend_last_q)) begin
      res_valid_o = 1'b1;
      res_o       = pend_r_q;
      res_o.last  = !res_valid_q;
    end else if (res_valid_q && scan_end_q) begin
      res_valid_o = 1'b1;
      res_o.last  = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth))
    else $error("stack count over depth");
  a_compact_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compact_step |-> wr_q <= rd_q)
    else $error("compaction pointers crossed");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec_simple && it_q.kind == 3'(KIND_CLEAR)) |=> cnt_q == '0)
    else $error("clear left entries");
`endif

endmodule

/* rtl/chunk_nesting_validator.sv */
// Chunk nesting validator.
// Items enter on item_i with start_i; one is accepted when start_i is high and
// busy_o is low. Results leave on result_o, each marked by result_valid_o for
// exactly one cycle; result_o.last marks the final result of an item. The
// receiver cannot stall, so every result must be taken as it appears.
// Load, push, verify, clear, the error cases of pop and a final check on an
// empty stack are settled in the DECIDE state and their result is registered
// from there; kinds six and seven pass the same way but give no result.
// A pop scans the stacked entries top to bottom for missing subchunks, again
// for popped chunks, then compacts the stack. A pop that pops nothing skips the
// compaction; one that reports missing subchunks ends after the first scan, and
// a final check on a non-empty stack makes a single scan. The stack scans
// examine one entry per cycle.
// busy_o stays high until the last result of the item has been produced.
// Reset clears the stack count and every descriptor valid bit; descriptor and
// stack contents are not cleared and are never read before being written.
module chunk_nesting_validator
  import cnv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  cnv_in_t  item_i,
  output logic     result_valid_o,
  output cnv_out_t result_o
);

  cnv_cmd_t cmd;
  cnv_sts_t sts;
  logic     ctrl_busy;
  logic     dp_valid;
  cnv_out_t dp_res;
  logic     drain_q;

  cnv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && !drain_q),
    .busy_o (ctrl_busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cnv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(dp_valid),
    .res_o      (dp_res)
  );

  // Results trail the controller through the datapath result and pending
  // registers; hold busy until the last one has gone out.
  logic [1:0] tail_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      tail_q  <= {tail_q[0], ctrl_busy};
      drain_q <= ctrl_busy || tail_q[0];
    end
  end

  assign busy_o         = ctrl_busy || drain_q || tail_q[1];
  assign result_valid_o = dp_valid;
  assign result_o       = dp_res;

endmodule

/* tb/sv/chunk_nesting_validator_checker.sv */
module chunk_nesting_validator_checker
  import cnv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_o,
  input  cnv_in_t  item_i,
  input  logic     result_valid_o,
  input  cnv_out_t result_o,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] tbl_id    [DescEntries];
  logic [63:0] tbl_bound [DescEntries];
  logic        tbl_valid [DescEntries];
  logic        tbl_exact [DescEntries];
  logic        tbl_once  [DescEntries];
  logic        tbl_fin   [DescEntries];
  logic [15:0] tbl_req   [DescEntries];

  logic [31:0] nest_id    [StackDepth];
  logic [63:0] nest_size  [StackDepth];
  logic [63:0] nest_end   [StackDepth];
  int          nest_slot  [StackDepth];
  logic [15:0] nest_seen  [StackDepth];
  int          depth;

  cnv_out_t expected_q[$];
  cnv_out_t item_results[$];

  assign pending_o = expected_q.size();

  function automatic void emit(status_e st, logic [31:0] id, logic [63:0] sz, logic fin,
                               logic [15:0] miss, int lvl);
    cnv_out_t r;
    r.status         = st;
    r.chunk_id_out   = id;
    r.chunk_size_out = sz;
    r.finish_event   = fin;
    r.missing_mask   = miss;
    r.level          = lvl[3:0];
    r.last           = 1'b0;
    item_results.push_back(r);
  endfunction

  // Required slots not yet seen inside stack entry i; entries without a descriptor have none.
  function automatic logic [15:0] unmet(int i);
    if (nest_slot[i] < 0) return '0;
    return tbl_req[nest_slot[i]] & ~nest_seen[i];
  endfunction

  function automatic void predict(cnv_in_t it);
    int s;
    int top;
    int w;
    int cnt;
    logic [15:0] bit_s;
    logic [64:0] sum;
    s   = -1;
    top = depth - 1;
    case (it.kind)
      KIND_LOAD: begin
        tbl_id[it.desc_slot]    = it.chunk_id;
        tbl_bound[it.desc_slot] = it.chunk_size;
        tbl_req[it.desc_slot]   = it.desc_required;
        tbl_valid[it.desc_slot] = 1'b1;
        tbl_exact[it.desc_slot] = it.desc_exact;
        tbl_once[it.desc_slot]  = it.desc_once;
        tbl_fin[it.desc_slot]   = it.desc_finish;
        emit(ST_OK, '0, '0, 1'b0, '0, depth);
      end
      KIND_PUSH: begin
        for (int k = DescEntries - 1; k >= 0; k--)
          if (tbl_valid[k] && tbl_id[k] == it.chunk_id) s = k;
        if (s >= 0 && tbl_exact[s] && it.chunk_size != tbl_bound[s])
          emit(ST_WRONG_SZ, it.chunk_id, '0, 1'b0, '0, depth);
        else if (s >= 0 && !tbl_exact[s] && it.chunk_size < tbl_bound[s])
          emit(ST_TOO_SMALL, it.chunk_id, '0, 1'b0, '0, depth);
        else begin
          bit_s = (s >= 0) ? (16'h1 << s) : '0;
          if (s >= 0 && depth > 0 && tbl_once[s] && (nest_seen[top] & bit_s) != 0)
            emit(ST_TWICE, it.chunk_id, '0, 1'b0, '0, depth);
          else begin
            // The parent keeps the seen mark even if a later check rejects the chunk.
            if (depth > 0) nest_seen[top] |= bit_s;
            if (depth > 0 && (it.begin_pos > nest_end[top] || it.end_pos > nest_end[top]))
              emit(ST_OUTSIDE, it.chunk_id, '0, 1'b0, '0, depth);
            else if (depth >= StackDepth)
              emit(ST_FULL, it.chunk_id, '0, 1'b0, '0, depth);
            else begin
              nest_id[depth]   = it.chunk_id;
              nest_size[depth] = it.chunk_size;
              nest_end[depth]  = it.end_pos;
              nest_slot[depth] = s;
              nest_seen[depth] = '0;
              depth++;
              emit(ST_OK, '0, '0, 1'b0, '0, depth);
            end
          end
        end
      end
      KIND_POP: begin
        if (depth == 0) emit(ST_EMPTY, '0, '0, 1'b0, '0, 0);
        else if (it.end_pos > nest_end[top])
          emit(ST_PAST_END, nest_id[top], '0, 1'b0, '0, depth);
        else begin
          for (int i = top; i >= 0; i--)
            if (nest_end[i] == it.end_pos && unmet(i) != 0)
              emit(ST_MISSING, nest_id[i], '0, 1'b0, unmet(i), depth);
          if (item_results.size() == 0) begin
            cnt = depth;
            for (int i = top; i >= 0; i--)
              if (nest_end[i] == it.end_pos) begin
                cnt--;
                emit(ST_OK, nest_id[i], nest_size[i],
                     nest_slot[i] >= 0 && tbl_fin[nest_slot[i]], '0, cnt);
              end
            if (item_results.size() == 0) emit(ST_NONE_FIN, '0, '0, 1'b0, '0, depth);
            else begin
              w = 0;
              for (int i = 0; i < depth; i++)
                if (nest_end[i] != it.end_pos) begin
                  nest_id[w]   = nest_id[i];
                  nest_size[w] = nest_size[i];
                  nest_end[w]  = nest_end[i];
                  nest_slot[w] = nest_slot[i];
                  nest_seen[w] = nest_seen[i];
                  w++;
                end
              depth = w;
            end
          end
        end
      end
      KIND_VERIFY: begin
        sum = {1'b0, it.end_pos} + {1'b0, it.adv_len};
        if (depth > 0 && (sum[64] || sum[63:0] > nest_end[top]))
          emit(ST_ADV_OVER, nest_id[top], '0, 1'b0, '0, depth);
        else emit(ST_OK, '0, '0, 1'b0, '0, depth);
      end
      KIND_CLEAR: begin
        depth = 0;
        emit(ST_OK, '0, '0, 1'b0, '0, 0);
      end
      KIND_FINAL: begin
        for (int i = top; i >= 0; i--)
          if (unmet(i) != 0) emit(ST_MISSING, nest_id[i], '0, 1'b0, unmet(i), depth);
        if (item_results.size() == 0) emit(ST_OK, '0, '0, 1'b0, '0, depth);
      end
      default: ;
    endcase
    if (item_results.size() > 0) item_results[$].last = 1'b1;
    foreach (item_results[i]) expected_q.push_back(item_results[i]);
    item_results.delete();
  endfunction

  function automatic void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cnv_out_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      depth = 0;
      expected_q.delete();
      for (int k = 0; k < DescEntries; k++) tbl_valid[k] = 1'b0;
    end else begin
      if (result_valid_o === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result mismatch, expected no result, actual %h", $time, result_o);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          compare("status", e.status, result_o.status);
          compare("chunk_id_out", e.chunk_id_out, result_o.chunk_id_out);
          compare("chunk_size_out", e.chunk_size_out, result_o.chunk_size_out);
          compare("finish_event", e.finish_event, result_o.finish_event);
          compare("missing_mask", e.missing_mask, result_o.missing_mask);
          compare("level", e.level, result_o.level);
          compare("last", e.last, result_o.last);
        end
      end
      if (start_i && !busy_o) predict(item_i);
    end
  end
endmodule

/* tb/sv/chunk_nesting_validator_tb.sv */
module chunk_nesting_validator_tb
  import cnv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  cnv_in_t  item_i = '0;
  logic     result_valid_o;
  cnv_out_t result_o;
  int       fails;
  int       pending;
  int       cycles = 0;
  int       gap_pct = 0;
  int       sent = 0;

  logic [31:0] ids [7];
  logic [63:0] open_end [10];
  int          open_cnt = 0;
  logic [63:0] cur_pos = '0;

  chunk_nesting_validator DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o
  );

  chunk_nesting_validator_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[chunk_nesting_validator] ERROR");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send(cnv_in_t it);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    item_i  <= it;
    start_i <= 1'b1;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    sent++;
  endtask

  function automatic cnv_in_t blank(kind_e k);
    cnv_in_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction

  task automatic load(int slot, logic [31:0] id, logic [63:0] bound, logic ex, logic once,
                      logic [15:0] req, logic fin);
    cnv_in_t it;
    it = blank(KIND_LOAD);
    it.desc_slot = slot[3:0];
    it.chunk_id = id;
    it.chunk_size = bound;
    it.desc_exact = ex;
    it.desc_once = once;
    it.desc_required = req;
    it.desc_finish = fin;
    send(it);
  endtask

  task automatic push(logic [31:0] id, logic [63:0] sz, logic [63:0] b, logic [63:0] e);
    cnv_in_t it;
    it = blank(KIND_PUSH);
    it.chunk_id = id;
    it.chunk_size = sz;
    it.begin_pos = b;
    it.end_pos = e;
    send(it);
  endtask

  task automatic at_pos(kind_e k, logic [63:0] p, logic [63:0] adv);
    cnv_in_t it;
    it = blank(k);
    it.end_pos = p;
    it.adv_len = adv;
    send(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r;
    int n;
    cnv_in_t it;
    logic [63:0] room;
    logic [63:0] sz;
    r = $urandom_range(99);
    if (r < 7) begin
      it = blank(KIND_LOAD);
      it.kind          = 3'($urandom_range(0, 7));
      it.chunk_id      = $urandom;
      it.chunk_size    = rand64();
      it.begin_pos     = rand64();
      it.end_pos       = rand64();
      it.adv_len       = rand64();
      it.desc_slot     = 4'($urandom);
      it.desc_exact    = 1'($urandom);
      it.desc_once     = 1'($urandom);
      it.desc_required = 16'($urandom);
      it.desc_finish   = 1'($urandom);
      send(it);
    end else if (r < 15) begin
      load(int'($urandom_range(0, 5)), ids[$urandom_range(0, 5)],
           64'($urandom_range(0, 24)),
           $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
           ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom & 32'h3f),
           1'($urandom_range(0, 1)));
    end else if (r < 50) begin
      if (open_cnt == 0) begin
        cur_pos = 64'($urandom_range(0, 100));
        room = 64'(3000);
      end else room = open_end[open_cnt - 1] - cur_pos;
      sz = (room > 0) ? 64'($urandom_range(0, 32'(room))) : '0;
      if ($urandom_range(0, 5) == 0) sz = room;
      if ($urandom_range(0, 15) == 0) sz = room + 1;
      push(ids[$urandom_range(0, 6)], sz, cur_pos, cur_pos + sz);
      if (open_cnt < 10 && (open_cnt == 0 || sz <= room)) begin
        open_end[open_cnt] = cur_pos + sz;
        open_cnt++;
        cur_pos = cur_pos + 64'($urandom_range(0, 3));
      end
    end else if (r < 75) begin
      if (open_cnt == 0) at_pos(KIND_POP, rand64(), '0);
      else begin
        cur_pos = open_end[open_cnt - 1];
        at_pos(KIND_POP, cur_pos, '0);
        n = 0;
        for (int i = 0; i < open_cnt; i++)
          if (open_end[i] != cur_pos) begin
            open_end[n] = open_end[i];
            n++;
          end
        open_cnt = n;
      end
    end else if (r < 85) begin
      at_pos(KIND_VERIFY, cur_pos,
             ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 40)));
    end else if (r < 93) begin
      at_pos(KIND_FINAL, '0, '0);
    end else begin
      send(blank(KIND_CLEAR));
      open_cnt = 0;
    end
  endtask

  initial begin
    cnv_in_t it;
    int gaps [4] = '{0, 51, 36, 0};
    for (int i = 0; i < 6; i++) ids[i] = $urandom;
    ids[6] = ~ids[0] ^ 32'h1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items.
    load(0, ids[0], 10, 1'b0, 1'b0, 16'h0006, 1'b1);
    load(1, ids[1], 5, 1'b1, 1'b1, 16'h0000, 1'b0);
    load(2, ids[2], 0, 1'b0, 1'b0, 16'hfff0, 1'b1);
    load(15, 32'hffffffff, 64'hffffffffffffffff, 1'b1, 1'b1, 16'hffff, 1'b1);
    load(3, ids[0], 0, 1'b0, 1'b0, 16'h0000, 1'b0);
    push(ids[1], 4, 0, 4);
    push(ids[0], 9, 0, 9);
    push(ids[0], 100, 0, 100);
    push(ids[1], 5, 0, 5);
    push(ids[1], 5, 0, 5);
    push(ids[6], 200, 0, 200);
    at_pos(KIND_POP, 100, '0);
    at_pos(KIND_POP, 300, '0);
    at_pos(KIND_POP, 50, '0);
    at_pos(KIND_VERIFY, 10, 64'hffffffffffffffff);
    at_pos(KIND_VERIFY, 10, 20);
    at_pos(KIND_FINAL, '0, '0);
    push(ids[2], 10, 0, 10);
    at_pos(KIND_POP, 5, '0);
    at_pos(KIND_POP, 10, '0);
    push(32'hffffffff, 64'hffffffffffffffff, 0, 64'hffffffffffffffff);
    for (int i = 0; i < 7; i++) push(ids[6], 0, 0, 0);
    push(ids[6], 0, 0, 0);
    at_pos(KIND_POP, 0, '0);
    it = blank(KIND_CLEAR);
    it.kind = 3'd6;
    send(it);
    it.kind = 3'd7;
    send(it);
    send(blank(KIND_CLEAR));
    at_pos(KIND_POP, 0, '0);
    at_pos(KIND_VERIFY, 64'hffffffffffffffff, 64'hffffffffffffffff);
    at_pos(KIND_FINAL, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gaps[ph];
      for (int i = 0; i < 31; i++) random_item();
      drain();
    end

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("[chunk_nesting_validator] OK");
    end else begin
      $display("[chunk_nesting_validator] ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/cnv_pkg.sv
rtl/cnv_ctrl.sv
rtl/cnv_dp.sv
rtl/chunk_nesting_validator.sv
tb/sv/chunk_nesting_validator_checker.sv
tb/sv/chunk_nesting_validator_tb.sv
